>>> src/keypad_matrix_debounce_defines.svh
// Assertion helpers used by the checker of the keypad block.
`ifndef KEYPAD_MATRIX_DEBOUNCE_DEFINES_SVH
`define KEYPAD_MATRIX_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define KMD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keypad_matrix_debounce: check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define KMD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad_matrix_debounce: check failed");

`endif

>>> src/kmd_pkg.sv
package kmd_pkg;

   localparam int KEY_COUNT      = 16;
   localparam int KEY_CODE_WIDTH = 8;
   localparam int TIME_WIDTH     = 32;
   localparam int DEBOUNCE_WIDTH = 16;
   localparam int DIM_WIDTH      = 3;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   typedef enum logic {
      FUNC_SCAN = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEYMAP_LOW  = 3'd0,
      CSR_KEYMAP_HIGH = 3'd1,
      CSR_DEBOUNCE_MS = 3'd2,
      CSR_ROW_COUNT   = 3'd3,
      CSR_COL_COUNT   = 3'd4
   } csr_index_type;

   typedef logic [KEY_COUNT-1:0][KEY_CODE_WIDTH-1:0] keymap_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] row_count;
      logic [DIM_WIDTH-1:0] col_count;
   } scan_cfg_type;

   typedef struct packed {
      func_type              func;
      logic [KEY_COUNT-1:0]  pressed_keys;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [KEY_CODE_WIDTH-1:0] key_code;
      logic                      key_valid;
      logic [KEY_CODE_WIDTH-1:0] stable_key;
      logic [KEY_CODE_WIDTH-1:0] raw_key;
   } rsp_word_type;

endpackage

>>> src/kmd_scan.sv
module kmd_scan #(
   parameter int MAX_ROWS = 4,
   parameter int MAX_COLS = 4
) (
   input  kmd_pkg::keymap_type                     keymap,
   input  kmd_pkg::scan_cfg_type                   cfg,
   input  logic [kmd_pkg::KEY_COUNT-1:0]           pressed_keys,
   output logic [kmd_pkg::KEY_CODE_WIDTH-1:0]      code
);
   import kmd_pkg::*;

   localparam logic [DIM_WIDTH-1:0] RowLimit = DIM_WIDTH'(MAX_ROWS);
   localparam logic [DIM_WIDTH-1:0] ColLimit = DIM_WIDTH'(MAX_COLS);
   localparam int CountWidth = $clog2(KEY_COUNT + 1);

   logic [DIM_WIDTH-1:0]  rows;
   logic [DIM_WIDTH-1:0]  cols;
   logic [CountWidth-1:0] keys_in_use;

   // Clamp the dimensions to what the matrix wiring provides.
   assign rows        = (cfg.row_count > RowLimit) ? RowLimit : cfg.row_count;
   assign cols        = (cfg.col_count > ColLimit) ? ColLimit : cfg.col_count;
   assign keys_in_use = CountWidth'(rows) * CountWidth'(cols);

   // Row-major indexes are contiguous, so the highest pressed key in use wins.
   always_comb begin
      code = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (pressed_keys[i] && (CountWidth'(i) < keys_in_use)) begin
            code = keymap[i];
         end
      end
   end

endmodule

>>> src/keypad_matrix_debounce.sv
// Channel   Ports                          Direction  Moves
// request   req_valid/req_ready/req_data   in         scan frame or key read word
// response  rsp_valid/rsp_ready/rsp_data   out        one result word per request
// config    psel/penable/pwrite/paddr/...  in/out     APB register access, 64-bit data
//
// Each request word is worked in the cycle it is accepted: one word per cycle while req_ready is high,
// set by the single-pass scan, compare and debounce update into the state registers.
// Its result is registered into the output entry, or into the skid entry while the output entry stalls.
// Results leave through a two-entry buffer, so req_ready stays high while one
// result waits; it drops only when both entries are full.
// Synchronous reset clears the debounce state, the buffer and the registers
// to their reset values (debounce 20 ms, four rows, four columns).
module keypad_matrix_debounce #(
   parameter int MAX_ROWS = 4,
   parameter int MAX_COLS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  kmd_pkg::req_word_type                  req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output kmd_pkg::rsp_word_type                  rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [kmd_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [kmd_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [kmd_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                   pready
);
   import kmd_pkg::*;

   localparam logic [DEBOUNCE_WIDTH-1:0] DebounceReset = 16'd20;
   localparam logic [DIM_WIDTH-1:0]      DimReset      = 3'd4;

   // Configuration registers.
   logic [CSR_DATA_WIDTH-1:0] keymap_low_ff;
   logic [CSR_DATA_WIDTH-1:0] keymap_high_ff;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ms_ff;
   logic [DIM_WIDTH-1:0]      row_count_ff;
   logic [DIM_WIDTH-1:0]      col_count_ff;

   // Debounce state and its next values.
   logic [KEY_CODE_WIDTH-1:0] raw_code_ff,       raw_code_in;
   logic [TIME_WIDTH-1:0]     change_time_ff,    change_time_in;
   logic                      wait_release_ff,   wait_release_in;
   logic [KEY_CODE_WIDTH-1:0] debounced_code_ff, debounced_code_in;
   logic [KEY_CODE_WIDTH-1:0] pending_code_ff,   pending_code_in;
   logic                      pending_flag_ff,   pending_flag_in;

   // Result buffer: output entry plus skid entry.
   rsp_word_type rsp_ff,  rsp_in;
   logic         rsp_valid_ff,  rsp_valid_in;
   rsp_word_type skid_ff, skid_in;
   logic         skid_valid_ff, skid_valid_in;

   logic                      csr_write;
   csr_index_type             csr_index;
   scan_cfg_type              scan_cfg;
   logic [KEY_CODE_WIDTH-1:0] fresh_code;
   logic [TIME_WIDTH-1:0]     elapsed;
   logic                      req_take;
   logic                      rsp_take;
   rsp_word_type              result;

   // ---------------------------------------------------------------------
   // Register port: writes land on the access phase, reads are combinational.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         keymap_low_ff  <= '0;
         keymap_high_ff <= '0;
         debounce_ms_ff <= DebounceReset;
         row_count_ff   <= DimReset;
         col_count_ff   <= DimReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEYMAP_LOW:  keymap_low_ff  <= pwdata;
            CSR_KEYMAP_HIGH: keymap_high_ff <= pwdata;
            CSR_DEBOUNCE_MS: debounce_ms_ff <= pwdata[DEBOUNCE_WIDTH-1:0];
            CSR_ROW_COUNT:   row_count_ff   <= pwdata[DIM_WIDTH-1:0];
            CSR_COL_COUNT:   col_count_ff   <= pwdata[DIM_WIDTH-1:0];
            default: begin
               // Drop writes beyond the register list.
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_KEYMAP_LOW:  prdata = keymap_low_ff;
         CSR_KEYMAP_HIGH: prdata = keymap_high_ff;
         CSR_DEBOUNCE_MS: prdata = CSR_DATA_WIDTH'(debounce_ms_ff);
         CSR_ROW_COUNT:   prdata = CSR_DATA_WIDTH'(row_count_ff);
         CSR_COL_COUNT:   prdata = CSR_DATA_WIDTH'(col_count_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Matrix scan: highest pressed key in use through the keymap.
   // ---------------------------------------------------------------------
   assign scan_cfg.row_count = row_count_ff;
   assign scan_cfg.col_count = col_count_ff;

   kmd_scan #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_scan (
      .keymap       (keymap_type'({keymap_high_ff, keymap_low_ff})),
      .cfg          (scan_cfg),
      .pressed_keys (req_data.pressed_keys),
      .code         (fresh_code)
   );

   // ---------------------------------------------------------------------
   // Debounce and pending-key update for the word on the request port.
   // ---------------------------------------------------------------------
   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      raw_code_in       = raw_code_ff;
      change_time_in    = change_time_ff;
      wait_release_in   = wait_release_ff;
      debounced_code_in = debounced_code_ff;
      pending_code_in   = pending_code_ff;
      pending_flag_in   = pending_flag_ff;
      result.key_code   = '0;
      result.key_valid  = 1'b0;
      elapsed           = req_data.now_ms - change_time_ff;

      if (req_data.func == FUNC_READ) begin
         // Hand out the waiting key once, then clear it.
         if (pending_flag_ff) begin
            result.key_code  = pending_code_ff;
            result.key_valid = 1'b1;
            pending_flag_in  = 1'b0;
         end
      end else begin
         // A change of raw code restarts the hold time.
         if (fresh_code != raw_code_ff) begin
            raw_code_in    = fresh_code;
            change_time_in = req_data.now_ms;
         end
         elapsed = req_data.now_ms - change_time_in;
         if (elapsed >= TIME_WIDTH'(debounce_ms_ff)) begin
            if (raw_code_in == '0) begin
               // Release: clear the stable key and re-arm press detection.
               wait_release_in   = 1'b0;
               debounced_code_in = '0;
            end else if (!wait_release_ff) begin
               // New press: latch it as pending unless a key already waits.
               wait_release_in   = 1'b1;
               debounced_code_in = raw_code_in;
               if (!pending_flag_ff) begin
                  pending_code_in = raw_code_in;
                  pending_flag_in = 1'b1;
               end
            end
         end
      end

      result.stable_key = debounced_code_in;
      result.raw_key    = raw_code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_code_ff       <= '0;
         change_time_ff    <= '0;
         wait_release_ff   <= 1'b0;
         debounced_code_ff <= '0;
         pending_code_ff   <= '0;
         pending_flag_ff   <= 1'b0;
      end else if (req_take) begin
         raw_code_ff       <= raw_code_in;
         change_time_ff    <= change_time_in;
         wait_release_ff   <= wait_release_in;
         debounced_code_ff <= debounced_code_in;
         pending_code_ff   <= pending_code_in;
         pending_flag_ff   <= pending_flag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result buffer: fill the output entry first, spill to skid when it stalls.
   // ---------------------------------------------------------------------
   assign rsp_take = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;

      if (rsp_take) begin
         // Advance the skid word into the output entry, or empty it.
         rsp_in        = skid_ff;
         rsp_valid_in  = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_take) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/kmd_checker.sv
`include "keypad_matrix_debounce_defines.svh"

module kmd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input kmd_pkg::rsp_word_type rsp_data
);
   import kmd_pkg::*;

   // A consumed key always carries a non-zero code; otherwise the code is zero.
   `KMD_ASSERT_NOW(a_key_valid_code, rsp_valid, rsp_data.key_valid == (rsp_data.key_code != '0))

   // Back-pressure on requests only once a result already waits.
   `KMD_ASSERT_NOW(a_ready_low_needs_result, !req_ready, rsp_valid)

   // A stalled result word holds.
   `KMD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A request accepted into an empty block yields a result next cycle.
   `KMD_ASSERT_NEXT(a_req_gives_rsp, req_valid && req_ready && !rsp_valid, rsp_valid)

endmodule

bind keypad_matrix_debounce kmd_checker u_kmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/keypad_matrix_debounce_tb.sv
module keypad_matrix_debounce_tb;
   import kmd_pkg::*;

   localparam int MAX_ROWS       = 4;
   localparam int MAX_COLS       = 4;
   // Cycles with no word, result or register write moving before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 4000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_word_type              req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_word_type              rsp_data;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   keypad_matrix_debounce #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 20-unit period: low half, then high half.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow copy of the keypad: register settings and debounce state.
   // ---------------------------------------------------------------------------
   logic [63:0] keymap_lo = '0;
   logic [63:0] keymap_hi = '0;
   logic [15:0] hold_ms   = 16'd20;
   logic [2:0]  rows_set  = 3'd4;
   logic [2:0]  cols_set  = 3'd4;

   logic [7:0]  seen_code        = '0;   // latest undebounced code
   logic [31:0] seen_since_ms    = '0;   // when that code last changed
   logic        awaiting_release = 1'b0; // a press was taken; hold off until a release
   logic [7:0]  settled_code     = '0;
   logic [7:0]  queued_code      = '0;   // one-shot key waiting for a read
   logic        queued_flag      = 1'b0;

   rsp_word_type keypad_reports_due[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count    = 0;
   int unsigned frames_sent    = 0;
   int unsigned reads_sent     = 0;
   int unsigned reports_checked = 0;
   int unsigned settings_applied = 0;
   int unsigned stall_cycles   = 0;
   logic [31:0] scan_ms        = '0;   // running timestamp for well-formed frames

   // Rows and columns actually scanned: counts above the matrix size saturate.
   function automatic int unsigned rows_in_use();
      return (rows_set > MAX_ROWS) ? MAX_ROWS : rows_set;
   endfunction

   function automatic int unsigned cols_in_use();
      return (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
   endfunction

   // Advance the shadow state by one word and return the result it should produce.
   function automatic rsp_word_type predict_keypad_report(input req_word_type w);
      rsp_word_type rep;
      logic [7:0]   fresh;
      logic [31:0]  held;
      int unsigned  rows, cols, ri, ci, idx;
      rep = '0;
      if (w.func == FUNC_READ) begin
         // A read consumes the queued key, if any; time and keys are ignored.
         if (queued_flag) begin
            rep.key_code  = queued_code;
            rep.key_valid = 1'b1;
            queued_flag   = 1'b0;
         end
      end else begin
         rows  = rows_in_use();
         cols  = cols_in_use();
         fresh = '0;
         // Row-major walk: the last pressed key visited wins.
         for (ri = 0; ri < rows; ri++) begin
            for (ci = 0; ci < cols; ci++) begin
               idx = (ri * cols + ci) & 15;
               if (w.pressed_keys[idx])
                  fresh = (idx < 8) ? keymap_lo[idx*8 +: 8] : keymap_hi[(idx-8)*8 +: 8];
            end
         end
         if (fresh != seen_code) begin
            seen_code     = fresh;
            seen_since_ms = w.now_ms;
         end
         held = w.now_ms - seen_since_ms;   // wraps modulo 2^32
         if (held >= {16'b0, hold_ms}) begin
            if (seen_code == 8'd0) begin
               awaiting_release = 1'b0;
               settled_code     = 8'd0;
            end else if (!awaiting_release) begin
               awaiting_release = 1'b1;
               settled_code     = seen_code;
               if (!queued_flag) begin
                  queued_code = seen_code;
                  queued_flag = 1'b1;
               end
            end
         end
      end
      rep.stable_key = settled_code;
      rep.raw_key    = seen_code;
      return rep;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: predict on every accepted word, check every accepted result,
   // and watch for a hung handshake.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (keypad_reports_due.size() == 0) begin
               $error("unexpected result word: %p", rsp_data);
               error_count++;
            end else begin
               want = keypad_reports_due.pop_front();
               reports_checked++;
               if (rsp_data.key_code !== want.key_code) begin
                  $error("key_code: expected %0h, got %0h", want.key_code, rsp_data.key_code);
                  error_count++;
               end
               if (rsp_data.key_valid !== want.key_valid) begin
                  $error("key_valid: expected %0b, got %0b",
                         want.key_valid, rsp_data.key_valid);
                  error_count++;
               end
               if (rsp_data.stable_key !== want.stable_key) begin
                  $error("stable_key: expected %0h, got %0h",
                         want.stable_key, rsp_data.stable_key);
                  error_count++;
               end
               if (rsp_data.raw_key !== want.raw_key) begin
                  $error("raw_key: expected %0h, got %0h", want.raw_key, rsp_data.raw_key);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            keypad_reports_due.push_back(predict_keypad_report(req_data));
            if (req_data.func == FUNC_READ)
               reads_sent++;
            else
               frames_sent++;
         end
         // Any word, result or register write moving resets the watchdog.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pwrite && pready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("keypad_matrix_debounce_tb: done, errors");
            $finish;
         end
      end
   end

   // Receiver: stall at random, at the rate the current phase asks for.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Offer one word; idle first at random, then hold it until taken.
   task automatic send_word(input func_type f, input logic [15:0] keys,
                            input logic [31:0] stamp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: f, pressed_keys: keys, now_ms: stamp};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold off until every predicted result has been taken.
   task automatic wait_reports_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (keypad_reports_due.size() != 0) @(negedge clock);
   endtask

   // Register write with setup and access phases; mirror it into the shadow copy when it lands.
   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {CSR_INDEX_LSB{1'b0}}};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_KEYMAP_LOW:  keymap_lo = value;
         CSR_KEYMAP_HIGH: keymap_hi = value;
         CSR_DEBOUNCE_MS: hold_ms   = value[15:0];
         CSR_ROW_COUNT:   rows_set  = value[2:0];
         CSR_COL_COUNT:   cols_set  = value[2:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drain, then load a complete register setting.
   task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [15:0] hold, input logic [2:0] rows,
                                input logic [2:0] cols);
      wait_reports_drained();
      csr_write(CSR_KEYMAP_LOW, lo);
      csr_write(CSR_KEYMAP_HIGH, hi);
      csr_write(CSR_DEBOUNCE_MS, {48'b0, hold});
      csr_write(CSR_ROW_COUNT, {61'b0, rows});
      csr_write(CSR_COL_COUNT, {61'b0, cols});
      settings_applied++;
   endtask

   // Mostly well-formed press / hold / release sessions with reads mixed in,
   // plus contact bounce and raw noise words.
   task automatic scan_random_sessions(input int unsigned word_total);
      int unsigned sent, in_use, span, holds;
      logic [15:0] keys;
      sent   = 0;
      in_use = rows_in_use() * cols_in_use();
      span   = hold_ms + (hold_ms >> 1) + 1;
      while (sent < word_total) begin
         case ($urandom_range(9))
            0: begin
               // noise: any function, any keys, any time
               send_word(func_type'($urandom_range(1)), 16'($urandom), $urandom);
               sent++;
            end
            1: begin
               // bounce: short-lived patterns up to two milliseconds apart
               repeat ($urandom_range(4, 1)) begin
                  scan_ms += $urandom_range(2);
                  send_word(FUNC_SCAN, 16'($urandom), scan_ms);
                  sent++;
               end
            end
            default: begin
               case ($urandom_range(3))
                  0:       keys = '0;
                  1:       keys = 16'($urandom);
                  default: keys = (in_use == 0) ? 16'($urandom)
                                                : 16'(1) << $urandom_range(in_use - 1);
               endcase
               holds = $urandom_range(5, 1);
               repeat (holds) begin
                  scan_ms += $urandom_range(span);
                  send_word(FUNC_SCAN, keys, scan_ms);
                  sent++;
                  if ($urandom_range(99) < 30) begin
                     send_word(FUNC_READ, 16'($urandom), $urandom);
                     sent++;
                  end
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset values: empty keymap, so any frame reads as no key; nothing queued.
   task automatic test_reset_state();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_word(FUNC_SCAN, 16'hFFFF, 32'h0000_0000);
      send_word(FUNC_SCAN, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(FUNC_READ, 16'h0000, 32'h0000_0000);
   endtask

   // Directed press, hold, read and release on a full 4x4 matrix.
   task automatic test_press_and_read();
      // index 5 maps to code 0, index 15 to all ones
      apply_setting(64'h0807_0005_0403_0201, 64'hFF0F_0E0D_0C0B_0A09, 16'd5, 3'd4, 3'd4);
      send_word(FUNC_SCAN, 16'h0001, 32'd100);        // raw change, not yet held
      send_word(FUNC_SCAN, 16'h0001, 32'd105);        // held exactly the hold time
      send_word(FUNC_READ, 16'hFFFF, 32'hFFFF_FFFF);  // takes the queued key
      send_word(FUNC_READ, 16'h0000, 32'd0);          // nothing left
      send_word(FUNC_SCAN, 16'h8009, 32'd106);        // highest index wins
      send_word(FUNC_SCAN, 16'h8009, 32'd200);        // still awaiting release
      send_word(FUNC_SCAN, 16'h0000, 32'd201);
      send_word(FUNC_SCAN, 16'h0000, 32'd206);        // release accepted
      send_word(FUNC_SCAN, 16'h0020, 32'd207);        // key with code 0
      send_word(FUNC_SCAN, 16'h0024, 32'd210);        // code-0 key wins over key 2
      send_word(FUNC_SCAN, 16'h8000, 32'd211);
      send_word(FUNC_SCAN, 16'h8000, 32'd216);        // press queued
      send_word(FUNC_SCAN, 16'h0000, 32'd217);
      send_word(FUNC_SCAN, 16'h0000, 32'd222);
      send_word(FUNC_SCAN, 16'h0200, 32'd223);
      send_word(FUNC_SCAN, 16'h0200, 32'd228);        // queue already full: kept
      send_word(FUNC_READ, 16'h1234, 32'd5);
      send_word(FUNC_READ, 16'h0000, 32'd6);
      send_word(FUNC_SCAN, 16'h0000, 32'd230);
      send_word(FUNC_SCAN, 16'h0000, 32'd235);
      send_word(FUNC_SCAN, 16'h0080, 32'hFFFF_FFFE);
      send_word(FUNC_SCAN, 16'h0080, 32'h0000_0003);  // held across the time wrap
      send_word(FUNC_READ, 16'hFFFF, 32'hFFFF_FFFF);
   endtask

   // Full matrix, reset-like hold time, no idling on either side.
   task automatic test_wide_scan();
      apply_setting({$urandom, $urandom} & 64'hFFFF_FFFF_FF00_FFFF, {$urandom, $urandom},
                    16'd20, 3'd4, 3'd4);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      scan_ms        = $urandom;
      scan_random_sessions(160);
   endtask

   // One key only, zero hold time, sender mostly idle.
   task automatic test_single_key();
      apply_setting('1, '0, 16'd0, 3'd1, 3'd1);
      send_idle_pct  = 69;
      recv_stall_pct = 0;
      scan_random_sessions(160);
   endtask

   // Part of the matrix in use, receiver mostly stalled.
   task automatic test_partial_matrix();
      apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'd7, 3'd2, 3'd3);
      send_idle_pct  = 0;
      recv_stall_pct = 69;
      scan_random_sessions(160);
   endtask

   // Zero rows, then zero columns: nothing is scanned.
   task automatic test_empty_matrix();
      apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'd3, 3'd0, 3'd4);
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      scan_random_sessions(30);
      apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'd3, 3'd3, 3'd0);
      scan_random_sessions(30);
   endtask

   // Oversized counts saturate; longest hold time, timestamps crossing the wrap.
   task automatic test_saturated_long_hold();
      apply_setting(64'h0, '1, 16'hFFFF, 3'd7, 3'd5);
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      scan_ms        = 32'hFFFA_0000;
      scan_random_sessions(160);
   endtask

   // Three rows, one-millisecond hold, both sides idling.
   task automatic test_quick_debounce();
      apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'd1, 3'd3, 3'd4);
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      scan_random_sessions(160);
   endtask

   // A single column of four keys, receiver mostly stalled.
   task automatic test_single_column();
      apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'd15, 3'd4, 3'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 69;
      scan_random_sessions(160);
   endtask

   initial begin
      // Every input known from time zero, with reset held high.
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_press_and_read();
      test_wide_scan();
      test_single_key();
      test_partial_matrix();
      test_empty_matrix();
      test_saturated_long_hold();
      test_quick_debounce();
      test_single_column();

      // Let the last results out, then watch for stray words.
      wait_reports_drained();
      repeat (4) @(posedge clock);

      $display("coverage: %0d scan frames and %0d key reads, %0d result words checked",
               frames_sent, reads_sent, reports_checked);
      $display("coverage: %0d register settings, matrices from empty to saturated 7x5",
               settings_applied);
      if (error_count == 0)
         $display("keypad_matrix_debounce_tb: done, clean");
      else
         $display("keypad_matrix_debounce_tb: done, errors");
      $finish;
   end

endmodule
